FILE: sv/keyboard_report_builder_unit_defines.svh
// Assertion helpers shared by the block's RTL.
// Each macro expects clk and rst to be visible where it is used.
`ifndef KEYBOARD_REPORT_BUILDER_UNIT_DEFINES_SVH
`define KEYBOARD_REPORT_BUILDER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, off during reset
`define KBR_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: implication check failed");

// Next-cycle implication, off during reset
`define KBR_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`else

`define KBR_ASSERT_IMP(label, ante, cons)
`define KBR_ASSERT_NXT(label, ante, cons)

`endif

`endif

FILE: sv/kbr_pkg.sv
package kbr_pkg;

  localparam int KEY_W            = 8;
  localparam int KIND_W           = 2;
  localparam int REPORT_POSITIONS = 6;
  localparam int FILL_W           = 3;
  localparam int QUEUE_DEPTH      = 2;
  localparam int QCOUNT_W         = 2;

  // Item kind codes as they arrive on the input channel
  typedef enum logic [KIND_W-1:0] {
    KIND_EVENT    = 2'd0,
    KIND_CLEAR    = 2'd1,
    KIND_QUERY    = 2'd2,
    KIND_MODIFIER = 2'd3
  } kind_t;

  // Decoded operation handed from front to back
  typedef enum logic [3:0] {
    OP_KEY   = 4'b0001,
    OP_CLEAR = 4'b0010,
    OP_QUERY = 4'b0100,
    OP_MOD   = 4'b1000
  } op_t;

  typedef struct packed {
    op_t              op;
    logic             is_low;
    logic [KEY_W-1:0] code;
    logic             press;
    logic [KEY_W-1:0] modifier;
  } cmd_t;

  typedef struct packed {
    logic [QCOUNT_W-1:0] count;
    logic                full;
  } fr_stat_t;

  typedef struct packed {
    logic busy;
    logic load;
  } bk_stat_t;

  // Back-end sequencer states
  typedef enum logic [5:0] {
    ST_IDLE       = 6'b000001,
    ST_FIND       = 6'b000010,
    ST_APPLY      = 6'b000100,
    ST_SCAN_BITS  = 6'b001000,
    ST_SCAN_SLOTS = 6'b010000,
    ST_DONE       = 6'b100000
  } bk_state_t;

endpackage

FILE: sv/kbr_in_if.sv
interface kbr_in_if;
  logic                     valid;
  logic                     ready;
  logic [kbr_pkg::KIND_W-1:0] kind;
  logic [kbr_pkg::KEY_W-1:0]  key_code;
  logic                     is_pressed;
  logic [kbr_pkg::KEY_W-1:0]  modifier_in;

  modport source (output valid, kind, key_code, is_pressed, modifier_in, input ready);
  modport sink (input valid, kind, key_code, is_pressed, modifier_in, output ready);
endinterface

FILE: sv/kbr_out_if.sv
interface kbr_out_if;
  logic                      valid;
  logic                      ready;
  logic                      key_down;
  logic [kbr_pkg::KEY_W-1:0] boot_modifier;
  logic [kbr_pkg::KEY_W-1:0] boot_key_0;
  logic [kbr_pkg::KEY_W-1:0] boot_key_1;
  logic [kbr_pkg::KEY_W-1:0] boot_key_2;
  logic [kbr_pkg::KEY_W-1:0] boot_key_3;
  logic [kbr_pkg::KEY_W-1:0] boot_key_4;
  logic [kbr_pkg::KEY_W-1:0] boot_key_5;

  modport source (
    output valid, key_down, boot_modifier,
           boot_key_0, boot_key_1, boot_key_2, boot_key_3, boot_key_4, boot_key_5,
    input  ready
  );
  modport sink (
    input  valid, key_down, boot_modifier,
           boot_key_0, boot_key_1, boot_key_2, boot_key_3, boot_key_4, boot_key_5,
    output ready
  );
endinterface

FILE: sv/keyboard_report_builder_unit.sv
// Keyboard report builder. Takes one item at a time (key event, clear, query
// or modifier write), updates a key bitmap for low keycodes and a small slot
// table for high ones, and returns for every item whether the addressed key is
// down together with a boot report: modifier byte plus up to BOOT_KEYS codes,
// bitmap keys in ascending order first, then occupied slots in slot order.
// Every item ends with a report scan that reads one bitmap bit and then one
// slot per cycle; an event on a high keycode first searches the slot table.
// A two-entry command queue sits in front of the scanner and a result
// register behind it, so input and output stall independently.
`include "keyboard_report_builder_unit_defines.svh"

module keyboard_report_builder_unit #(
  parameter int BITMAP_KEYS = 128,
  parameter int EXTRA_SLOTS = 8,
  parameter int BOOT_KEYS   = 6
) (
  input  logic      clk,
  input  logic      rst,
  kbr_in_if.sink    item,
  kbr_out_if.source report
);

  kbr_pkg::cmd_t     head;
  logic              head_valid;
  logic              head_pop;
  kbr_pkg::fr_stat_t fr_stat;
  kbr_pkg::bk_stat_t bk_stat;

  kbr_front #(
    .BITMAP_KEYS (BITMAP_KEYS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .head       (head),
    .head_valid (head_valid),
    .head_pop   (head_pop),
    .stat       (fr_stat)
  );

  kbr_back #(
    .BITMAP_KEYS (BITMAP_KEYS),
    .EXTRA_SLOTS (EXTRA_SLOTS),
    .BOOT_KEYS   (BOOT_KEYS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .head_pop   (head_pop),
    .report     (report),
    .stat       (bk_stat)
  );

  // An accepted transaction is in the queue on the next cycle
  `KBR_ASSERT_NXT(a_push_lands, item.valid && item.ready, fr_stat.count != '0)
  // A new result appears only after the scanner loaded it
  `KBR_ASSERT_IMP(a_result_from_load, $rose(report.valid), $past(bk_stat.load))
  // The scanner pulls a command only while it is idle
  `KBR_ASSERT_IMP(a_pop_only_idle, head_pop, !bk_stat.busy)

endmodule

FILE: sv/kbr_front.sv
module kbr_front #(
  parameter int BITMAP_KEYS = 128
) (
  input  logic              clk,
  input  logic              rst,
  kbr_in_if.sink            item,
  output kbr_pkg::cmd_t     head,
  output logic              head_valid,
  input  logic              head_pop,
  output kbr_pkg::fr_stat_t stat
);

  kbr_pkg::cmd_t                 cmd;
  kbr_pkg::cmd_t                 fifo_mem [kbr_pkg::QUEUE_DEPTH];
  logic                          wr_ptr;
  logic                          rd_ptr;
  logic [kbr_pkg::QCOUNT_W-1:0]  count;
  logic                          push;
  logic                          pop;

  // Classify the incoming transaction
  always_comb begin
    cmd.code     = item.key_code;
    cmd.press    = item.is_pressed;
    cmd.modifier = item.modifier_in;
    cmd.is_low   = ({1'b0, item.key_code} < 9'(BITMAP_KEYS));
    case (kbr_pkg::kind_t'(item.kind))
      kbr_pkg::KIND_EVENT:    cmd.op = kbr_pkg::OP_KEY;
      kbr_pkg::KIND_CLEAR:    cmd.op = kbr_pkg::OP_CLEAR;
      kbr_pkg::KIND_MODIFIER: cmd.op = kbr_pkg::OP_MOD;
      default:                cmd.op = kbr_pkg::OP_QUERY;
    endcase
  end

  assign item.ready = (count != kbr_pkg::QCOUNT_W'(kbr_pkg::QUEUE_DEPTH));
  assign push       = item.valid && item.ready;
  assign head_valid = (count != '0);
  assign pop        = head_pop && head_valid;
  assign head       = fifo_mem[rd_ptr];

  assign stat.count = count;
  assign stat.full  = !item.ready;

  // Advance queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + kbr_pkg::QCOUNT_W'(push) - kbr_pkg::QCOUNT_W'(pop);
    end
  end

  // Hold queued commands
  always_ff @(posedge clk) begin
    if (push) fifo_mem[wr_ptr] <= cmd;
  end

endmodule

FILE: sv/kbr_back.sv
module kbr_back #(
  parameter int BITMAP_KEYS = 128,
  parameter int EXTRA_SLOTS = 8,
  parameter int BOOT_KEYS   = 6
) (
  input  logic              clk,
  input  logic              rst,
  input  kbr_pkg::cmd_t     head,
  input  logic              head_valid,
  output logic              head_pop,
  kbr_out_if.source         report,
  output kbr_pkg::bk_stat_t stat
);

  localparam int BIT_W  = $clog2(BITMAP_KEYS);
  localparam int SLOT_W = (EXTRA_SLOTS > 1) ? $clog2(EXTRA_SLOTS) : 1;
  localparam int KW     = kbr_pkg::KEY_W;
  localparam int NPOS   = kbr_pkg::REPORT_POSITIONS;

  kbr_pkg::bk_state_t            state;
  kbr_pkg::cmd_t                 cur;
  logic [BITMAP_KEYS-1:0]        bitmap;
  logic [BITMAP_KEYS-1:0]        shadow;
  logic [KW-1:0]                 slots [EXTRA_SLOTS];
  logic [KW-1:0]                 modifier;
  logic [BIT_W-1:0]              bit_idx;
  logic [SLOT_W-1:0]             slot_idx;
  logic                          found;
  logic                          free_found;
  logic [SLOT_W-1:0]             found_idx;
  logic [SLOT_W-1:0]             free_idx;
  logic [kbr_pkg::FILL_W-1:0]    fill;
  logic [KW-1:0]                 keys [NPOS];
  logic                          down;
  logic                          out_valid;
  logic                          out_down;
  logic [KW-1:0]                 out_modifier;
  logic [KW-1:0]                 out_keys [NPOS];
  logic [KW-1:0]                 slot_val;
  logic                          slot_last;
  logic                          bit_last;
  logic                          room;
  logic                          load;

  assign slot_val  = slots[slot_idx];
  assign slot_last = (slot_idx == SLOT_W'(EXTRA_SLOTS - 1));
  assign bit_last  = (bit_idx == BIT_W'(BITMAP_KEYS - 1));
  assign room      = (fill < kbr_pkg::FILL_W'(BOOT_KEYS));
  assign head_pop  = (state == kbr_pkg::ST_IDLE) && head_valid;
  assign load      = (state == kbr_pkg::ST_DONE) && (!out_valid || report.ready);

  assign stat.busy = (state != kbr_pkg::ST_IDLE);
  assign stat.load = load;

  // Drive the result register onto the output channel
  assign report.valid         = out_valid;
  assign report.key_down      = out_down;
  assign report.boot_modifier = out_modifier;
  assign report.boot_key_0    = out_keys[0];
  assign report.boot_key_1    = out_keys[1];
  assign report.boot_key_2    = out_keys[2];
  assign report.boot_key_3    = out_keys[3];
  assign report.boot_key_4    = out_keys[4];
  assign report.boot_key_5    = out_keys[5];

  // Key state, sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= kbr_pkg::ST_IDLE;
      bitmap    <= '0;
      modifier  <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < EXTRA_SLOTS; i++) slots[i] <= '0;
    end else begin
      // Set on a load, drop once the transaction is taken
      if (load) out_valid <= 1'b1;
      else if (report.valid && report.ready) out_valid <= 1'b0;
      case (state)
        kbr_pkg::ST_IDLE: begin
          if (head_valid) begin
            cur        <= head;
            slot_idx   <= '0;
            found      <= 1'b0;
            free_found <= 1'b0;
            case (head.op)
              kbr_pkg::OP_KEY: begin
                if (head.is_low) begin
                  bitmap[head.code[BIT_W-1:0]] <= head.press;
                  state <= kbr_pkg::ST_APPLY;
                end else begin
                  state <= kbr_pkg::ST_FIND;
                end
              end
              kbr_pkg::OP_CLEAR: begin
                bitmap   <= '0;
                modifier <= '0;
                for (int i = 0; i < EXTRA_SLOTS; i++) slots[i] <= '0;
                state    <= kbr_pkg::ST_APPLY;
              end
              kbr_pkg::OP_MOD: begin
                modifier <= head.modifier;
                state    <= kbr_pkg::ST_APPLY;
              end
              default: state <= kbr_pkg::ST_APPLY;
            endcase
          end
        end
        // Look for the code and for the first empty slot
        kbr_pkg::ST_FIND: begin
          if (!found && slot_val == cur.code) begin
            found     <= 1'b1;
            found_idx <= slot_idx;
          end
          if (!free_found && slot_val == '0) begin
            free_found <= 1'b1;
            free_idx   <= slot_idx;
          end
          if (slot_last) begin
            slot_idx <= '0;
            state    <= kbr_pkg::ST_APPLY;
          end else begin
            slot_idx <= slot_idx + SLOT_W'(1);
          end
        end
        // Update the slot table, then snapshot the bitmap for the report scan
        kbr_pkg::ST_APPLY: begin
          if (cur.op == kbr_pkg::OP_KEY && !cur.is_low) begin
            if (found) begin
              if (!cur.press) slots[found_idx] <= '0;
            end else if (cur.press && free_found) begin
              slots[free_idx] <= cur.code;
            end
          end
          shadow  <= bitmap;
          bit_idx <= '0;
          fill    <= '0;
          down    <= 1'b0;
          for (int p = 0; p < NPOS; p++) keys[p] <= '0;
          state   <= kbr_pkg::ST_SCAN_BITS;
        end
        // Walk the bitmap one key per cycle in ascending order
        kbr_pkg::ST_SCAN_BITS: begin
          shadow <= shadow >> 1;
          if (shadow[0] && room) begin
            for (int p = 0; p < NPOS; p++) begin
              if (fill == kbr_pkg::FILL_W'(p)) keys[p] <= KW'(bit_idx);
            end
            fill <= fill + kbr_pkg::FILL_W'(1);
          end
          if (cur.is_low && cur.code[BIT_W-1:0] == bit_idx) down <= shadow[0];
          if (bit_last) begin
            slot_idx <= '0;
            state    <= kbr_pkg::ST_SCAN_SLOTS;
          end else begin
            bit_idx <= bit_idx + BIT_W'(1);
          end
        end
        // Walk the slot table in slot order
        kbr_pkg::ST_SCAN_SLOTS: begin
          if (slot_val != '0 && room) begin
            for (int p = 0; p < NPOS; p++) begin
              if (fill == kbr_pkg::FILL_W'(p)) keys[p] <= slot_val;
            end
            fill <= fill + kbr_pkg::FILL_W'(1);
          end
          if (!cur.is_low && slot_val == cur.code) down <= 1'b1;
          if (slot_last) state <= kbr_pkg::ST_DONE;
          else slot_idx <= slot_idx + SLOT_W'(1);
        end
        // Wait for the result register to free up
        kbr_pkg::ST_DONE: begin
          if (load) state <= kbr_pkg::ST_IDLE;
        end
        default: state <= kbr_pkg::ST_IDLE;
      endcase
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (load) begin
      out_down     <= down;
      out_modifier <= modifier;
      for (int p = 0; p < NPOS; p++) out_keys[p] <= keys[p];
    end
  end

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int BITMAP_KEYS     = 128;
  localparam int EXTRA_SLOTS     = 8;
  localparam int BOOT_KEYS       = 6;
  localparam int ITEMS_PER_PHASE = 577;
  localparam int HOLD_CYCLES     = 1500;
  localparam int DRAIN_CYCLES    = 300;
  localparam int STALL_LIMIT     = 20000;
  localparam int PRINT_LIMIT     = 100;
  localparam int PLAN_ROWS       = 21;

  typedef struct packed {
    kbr_pkg::kind_t            kind;
    logic [kbr_pkg::KEY_W-1:0] code;
    logic                      press;
    logic [kbr_pkg::KEY_W-1:0] modifier;
  } key_item_t;

  typedef struct packed {
    logic                                                   key_down;
    logic [kbr_pkg::KEY_W-1:0]                              modifier;
    logic [kbr_pkg::REPORT_POSITIONS-1:0][kbr_pkg::KEY_W-1:0] keys;
  } boot_report_t;

  typedef struct packed {
    key_item_t    item;
    logic         typed;
    boot_report_t want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  kbr_in_if  item_ch ();
  kbr_out_if report_ch ();

  keyboard_report_builder_unit #(
    .BITMAP_KEYS(BITMAP_KEYS),
    .EXTRA_SLOTS(EXTRA_SLOTS),
    .BOOT_KEYS  (BOOT_KEYS)
  ) DUT (
    .clk   (clk),
    .rst   (rst),
    .item  (item_ch),
    .report(report_ch)
  );

  always #5 clk = ~clk;

  // Shadow keyboard state
  logic [BITMAP_KEYS-1:0]    held_bits;
  logic [kbr_pkg::KEY_W-1:0] slot_tab [EXTRA_SLOTS];
  logic [kbr_pkg::KEY_W-1:0] mod_byte;

  boot_report_t pending_reports[$];

  int snd_idle_pct;
  int rcv_idle_pct;
  bit hold_req;
  int hold_left;
  int err_count;
  int reports_checked;
  int idle_cycles;
  int n_events, n_clears, n_queries, n_mods, full_drops, overflow_reports;

  // Directed items; keys are packed with position 0 in the low byte
  plan_row_t plan [PLAN_ROWS] = '{
    // reset state and modifier write
    '{'{kbr_pkg::KIND_QUERY,    8'd0,   1'b0, 8'h00}, 1'b1, '{1'b0, 8'h00, 48'h0}},
    '{'{kbr_pkg::KIND_MODIFIER, 8'd0,   1'b0, 8'hFF}, 1'b1, '{1'b0, 8'hFF, 48'h0}},
    // bitmap key zero takes a position that reads as unused
    '{'{kbr_pkg::KIND_EVENT,    8'd0,   1'b1, 8'h00}, 1'b1, '{1'b1, 8'hFF, 48'h0}},
    '{'{kbr_pkg::KIND_EVENT,    8'd127, 1'b1, 8'h00}, 1'b1, '{1'b1, 8'hFF, 48'h7F00}},
    '{'{kbr_pkg::KIND_EVENT,    8'd128, 1'b1, 8'h00}, 1'b1, '{1'b1, 8'hFF, 48'h80_7F00}},
    '{'{kbr_pkg::KIND_EVENT,    8'd255, 1'b1, 8'h00}, 1'b1, '{1'b1, 8'hFF, 48'hFF_807F00}},
    // press of a code already in a slot
    '{'{kbr_pkg::KIND_EVENT,    8'd128, 1'b1, 8'h00}, 1'b0, '0},
    // fill the slot table, overflowing the report
    '{'{kbr_pkg::KIND_EVENT,    8'd129, 1'b1, 8'h00}, 1'b0, '0},
    '{'{kbr_pkg::KIND_EVENT,    8'd130, 1'b1, 8'h00}, 1'b0, '0},
    '{'{kbr_pkg::KIND_EVENT,    8'd131, 1'b1, 8'h00}, 1'b0, '0},
    '{'{kbr_pkg::KIND_EVENT,    8'd132, 1'b1, 8'h00}, 1'b0, '0},
    '{'{kbr_pkg::KIND_EVENT,    8'd133, 1'b1, 8'h00}, 1'b0, '0},
    '{'{kbr_pkg::KIND_EVENT,    8'd134, 1'b1, 8'h00}, 1'b0, '0},
    // full table drops a new press
    '{'{kbr_pkg::KIND_EVENT,    8'd135, 1'b1, 8'h00}, 1'b0, '0},
    // release of an absent high code, then free a slot and reuse it
    '{'{kbr_pkg::KIND_EVENT,    8'd200, 1'b0, 8'h00}, 1'b0, '0},
    '{'{kbr_pkg::KIND_EVENT,    8'd255, 1'b0, 8'h00}, 1'b0, '0},
    '{'{kbr_pkg::KIND_EVENT,    8'd136, 1'b1, 8'h00}, 1'b0, '0},
    '{'{kbr_pkg::KIND_QUERY,    8'd134, 1'b0, 8'h00}, 1'b0, '0},
    '{'{kbr_pkg::KIND_MODIFIER, 8'd255, 1'b0, 8'h00}, 1'b0, '0},
    // clear wipes everything
    '{'{kbr_pkg::KIND_CLEAR,    8'd127, 1'b1, 8'hA5}, 1'b1, '{1'b0, 8'h00, 48'h0}},
    '{'{kbr_pkg::KIND_EVENT,    8'd5,   1'b0, 8'h00}, 1'b0, '0}
  };

  // Apply one item to the shadow state and build the report it yields
  function automatic boot_report_t advance_keyboard(key_item_t it);
    boot_report_t r;
    int           n;
    int           i;
    int           total;
    bit           found;
    r     = '0;
    n     = 0;
    total = 0;
    found = 1'b0;
    case (it.kind)
      kbr_pkg::KIND_EVENT: begin
        n_events++;
        if (it.code < BITMAP_KEYS) begin
          held_bits[it.code] = it.press;
        end else begin
          for (i = 0; i < EXTRA_SLOTS; i++) begin
            if (!found && slot_tab[i] == it.code) begin
              found = 1'b1;
              if (!it.press) slot_tab[i] = '0;
            end
          end
          if (!found && it.press) begin
            for (i = 0; i < EXTRA_SLOTS; i++) begin
              if (!found && slot_tab[i] == '0) begin
                slot_tab[i] = it.code;
                found       = 1'b1;
              end
            end
            if (!found) full_drops++;
          end
        end
      end
      kbr_pkg::KIND_CLEAR: begin
        n_clears++;
        held_bits = '0;
        for (i = 0; i < EXTRA_SLOTS; i++) slot_tab[i] = '0;
        mod_byte = '0;
      end
      kbr_pkg::KIND_MODIFIER: begin
        n_mods++;
        mod_byte = it.modifier;
      end
      default: begin
        n_queries++;
      end
    endcase

    // Bitmap keys in ascending order, then occupied slots in slot order
    for (i = 0; i < BITMAP_KEYS; i++) begin
      if (held_bits[i]) begin
        if (n < BOOT_KEYS) begin
          r.keys[n] = i[kbr_pkg::KEY_W-1:0];
          n++;
        end
        total++;
      end
    end
    for (i = 0; i < EXTRA_SLOTS; i++) begin
      if (slot_tab[i] != '0) begin
        if (n < BOOT_KEYS) begin
          r.keys[n] = slot_tab[i];
          n++;
        end
        total++;
      end
    end
    if (total > BOOT_KEYS) overflow_reports++;

    r.modifier = mod_byte;
    if (it.code < BITMAP_KEYS) begin
      r.key_down = held_bits[it.code];
    end else begin
      for (i = 0; i < EXTRA_SLOTS; i++) begin
        if (slot_tab[i] == it.code) r.key_down = 1'b1;
      end
    end
    return r;
  endfunction

  // Draw a random item, biased toward a small pool of keys so that
  // releases hit held keys and the slot table fills up
  function automatic key_item_t draw_item();
    key_item_t it;
    int        w;
    w = $urandom_range(99);
    if (w < 72) it.kind = kbr_pkg::KIND_EVENT;
    else if (w < 85) it.kind = kbr_pkg::KIND_QUERY;
    else if (w < 97) it.kind = kbr_pkg::KIND_MODIFIER;
    else it.kind = kbr_pkg::KIND_CLEAR;
    w = $urandom_range(99);
    if (w < 40) it.code = kbr_pkg::KEY_W'($urandom_range(11));
    else if (w < 50) it.code = kbr_pkg::KEY_W'($urandom_range(127, 116));
    else if (w < 85) it.code = kbr_pkg::KEY_W'($urandom_range(141, 128));
    else it.code = kbr_pkg::KEY_W'($urandom_range(255));
    it.press    = ($urandom_range(99) < 65);
    it.modifier = kbr_pkg::KEY_W'($urandom_range(255));
    return it;
  endfunction

  // Offer one item and record its expected report once the transaction completes
  task automatic send_item(key_item_t it, bit typed, boot_report_t want);
    boot_report_t predicted;
    while ($urandom_range(99) < snd_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid       <= 1'b1;
    item_ch.kind        <= it.kind;
    item_ch.key_code    <= it.code;
    item_ch.is_pressed  <= it.press;
    item_ch.modifier_in <= it.modifier;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    predicted = advance_keyboard(it);
    pending_reports.push_back(typed ? want : predicted);
  endtask

  // Hold the input idle until every expected report has arrived
  task automatic wait_reports_drained();
    item_ch.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
  endtask

  task automatic report_mismatch(string what, int got, int want);
    if (err_count < PRINT_LIMIT) begin
      $display("%0t: report %0d mismatch on %s: got 0x%0h, want 0x%0h",
               $realtime, reports_checked, what, got, want);
    end
    err_count++;
  endtask

  // Compare one report transaction with the oldest expectation
  task automatic check_report();
    boot_report_t got;
    boot_report_t want;
    int           i;
    got.key_down = report_ch.key_down;
    got.modifier = report_ch.boot_modifier;
    got.keys[0]  = report_ch.boot_key_0;
    got.keys[1]  = report_ch.boot_key_1;
    got.keys[2]  = report_ch.boot_key_2;
    got.keys[3]  = report_ch.boot_key_3;
    got.keys[4]  = report_ch.boot_key_4;
    got.keys[5]  = report_ch.boot_key_5;
    if (pending_reports.size() == 0) begin
      report_mismatch("unexpected report", 1, 0);
    end else begin
      want = pending_reports.pop_front();
      if (got.key_down !== want.key_down) report_mismatch("key_down", got.key_down, want.key_down);
      if (got.modifier !== want.modifier) begin
        report_mismatch("boot_modifier", got.modifier, want.modifier);
      end
      for (i = 0; i < kbr_pkg::REPORT_POSITIONS; i++) begin
        if (got.keys[i] !== want.keys[i]) begin
          report_mismatch($sformatf("boot_key_%0d", i), got.keys[i], want.keys[i]);
        end
      end
    end
    reports_checked++;
  endtask

  // Receiver: check each report transaction, then pick next cycle's ready
  always @(posedge clk) begin
    if (!rst) begin
      if (report_ch.valid && report_ch.ready) check_report();
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        report_ch.ready <= 1'b0;
      end else begin
        report_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  // Watchdog: end the run when no transaction moves for too long
  always @(posedge clk) begin
    if (rst || (item_ch.valid && item_ch.ready) || (report_ch.valid && report_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int ph;
    int n;
    int r;
    item_ch.valid       = 1'b0;
    item_ch.kind        = kbr_pkg::KIND_EVENT;
    item_ch.key_code    = '0;
    item_ch.is_pressed  = 1'b0;
    item_ch.modifier_in = '0;
    report_ch.ready     = 1'b0;
    held_bits = '0;
    for (int i = 0; i < EXTRA_SLOTS; i++) slot_tab[i] = '0;
    mod_byte  = '0;
    hold_req  = 1'b0;
    hold_left = 0;
    snd_idle_pct = 17;
    rcv_idle_pct = 68;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed table
    for (r = 0; r < PLAN_ROWS; r++) begin
      send_item(plan[r].item, plan[r].typed, plan[r].want);
    end

    // Random phases: sender-light, receiver-light, then no idling
    for (ph = 0; ph < 3; ph++) begin
      snd_idle_pct = (ph == 0) ? 17 : (ph == 1) ? 68 : 0;
      rcv_idle_pct = (ph == 0) ? 68 : (ph == 1) ? 17 : 0;
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (ph == 0 && n == 60) hold_req = 1'b1;
        if (ph == 1 && n == 250) wait_reports_drained();
        send_item(draw_item(), 1'b0, '0);
      end
    end

    wait_reports_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d reports: %0d events, %0d queries, %0d modifier writes, %0d clears",
             reports_checked, n_events, n_queries, n_mods, n_clears);
    $display("Dropped presses on a full slot table: %0d, reports with overflow: %0d",
             full_drops, overflow_reports);
    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
